// File: rtl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg: shared types and constants for the indent row tokenizer
// Result kinds, character classes, level width and the result record.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int unsigned LEVEL_BITS = 16;
    localparam int unsigned OUT_LEVEL_BITS = 16;
    localparam logic [OUT_LEVEL_BITS-1:0] OUT_LEVEL_MAX = '1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

    // result kinds
    localparam logic [2:0] K_KEY  = 3'd0;
    localparam logic [2:0] K_CONN = 3'd1;
    localparam logic [2:0] K_ROW  = 3'd2;
    localparam logic [2:0] K_ERR  = 3'd3;
    localparam logic [2:0] K_ACC  = 3'd4;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef struct packed {
        logic [2:0]                kind;
        logic [7:0]                ch;
        logic [OUT_LEVEL_BITS-1:0] level;
        logic                      last;
    } t_res;

    function automatic logic is_lower(input logic [7:0] c);
        return (c > 8'd96) && (c < 8'd123);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c > 8'd47) && (c < 8'd58);
    endfunction

    function automatic logic is_single_conn(input logic [7:0] c);
        return (c == 8'h3A) || (c == 8'h3B) || (c == 8'h2C) || (c == 8'h28) ||
               (c == 8'h29) || (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) ||
               (c == 8'h2F);
    endfunction

    function automatic logic [OUT_LEVEL_BITS-1:0] sat_level(
        input logic [LEVEL_BITS-1:0] v
    );
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'(OUT_LEVEL_MAX)) ? OUT_LEVEL_MAX : w[OUT_LEVEL_BITS-1:0];
    endfunction

    function automatic t_res mk_res(
        input logic [2:0]                kind,
        input logic [7:0]                ch,
        input logic [OUT_LEVEL_BITS-1:0] level
    );
        t_res r;
        r.kind  = kind;
        r.ch    = ((kind == K_KEY) || (kind == K_CONN)) ? ch : 8'd0;
        r.level = (kind == K_ROW) ? level : '0;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/indent_row_tokenizer.sv
// ----------------------------------------------------------------------------
// indent_row_tokenizer: byte-serial key/connector row checker
// Results of a byte are registered into the result queue on its transfer.
// Throughput: one byte per cycle; a byte yields 0..2 results, drained one per
// cycle while the output is ready, through a four-entry result queue, so input
// stalls only when the queue holds more than two results.
// Reset: synchronous, active low; clears parser state and empties the queue.
// ----------------------------------------------------------------------------
module indent_row_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tlast,   // is_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_char, [23:8] row_level
    output logic [2:0]  o_m_tuser,   // [2:0] kind
    output logic        o_m_tlast    // last
);
    import irt_pkg::*;

    localparam logic [2:0] PH_KEY   = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_INT   = 3'd2;
    localparam logic [2:0] PH_DOT   = 3'd3;
    localparam logic [2:0] PH_FRAC  = 3'd4;
    localparam logic [2:0] PH_ARROW = 3'd5;
    localparam logic [2:0] PH_HALT  = 3'd6;

    localparam logic [1:0] SM_NORMAL = 2'd0;
    localparam logic [1:0] SM_NLRUN  = 2'd1;
    localparam logic [1:0] SM_COUNT  = 2'd2;

    logic [2:0]            r_phase, n_phase;
    logic [1:0]            r_mode,  n_mode;
    logic [LEVEL_BITS-1:0] r_count, n_count;
    logic [LEVEL_BITS-1:0] r_level, n_level;

    t_res       r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    t_res       res_a, res_b;
    logic [1:0] n_res;
    logic       in_xfer, out_xfer;

    logic [LEVEL_BITS-1:0]     lvl_eff;
    logic [OUT_LEVEL_BITS-1:0] lvl_out;
    logic [7:0]                c;
    logic                      is_ws;

    assign o_s_tready = (r_cnt < 3'd3);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_cnt != 3'd0);
    assign out_xfer   = o_m_tvalid && i_m_tready;

    assign o_m_tdata = {r_mem[r_rd].level, r_mem[r_rd].ch};
    assign o_m_tuser = r_mem[r_rd].kind;
    assign o_m_tlast = r_mem[r_rd].last;

    assign c       = i_s_tdata;
    assign is_ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    // level as it stands once any pending whitespace run is closed
    assign lvl_eff = (r_mode != SM_NORMAL) ? r_count : r_level;
    assign lvl_out = sat_level(lvl_eff);

    always_comb begin
        n_phase = r_phase;
        n_mode  = r_mode;
        n_count = r_count;
        n_level = r_level;
        res_a   = mk_res(K_ERR, 8'd0, '0);
        res_b   = mk_res(K_ERR, 8'd0, '0);
        n_res   = 2'd0;

        if (i_s_tlast) begin
            priority if (r_phase == PH_KEY) begin
                res_a = mk_res(K_ACC, 8'd0, '0);
                n_res = 2'd1;
            end else if (r_phase == PH_ARROW) begin
                res_a = mk_res(K_ROW, 8'd0, lvl_out);
                res_b = mk_res(K_ACC, 8'd0, '0);
                n_res = 2'd2;
            end else if (r_phase != PH_HALT) begin
                res_a = mk_res(K_ERR, 8'd0, '0);
                n_res = 2'd1;
            end else begin
                n_res = 2'd0;
            end
            n_phase = PH_KEY;
            n_mode  = SM_NORMAL;
            n_count = '0;
            n_level = '0;
        end else if (r_phase == PH_HALT) begin
            n_res = 2'd0;
        end else if (is_ws) begin
            unique case (r_mode)
                SM_NORMAL: begin
                    if (c == CH_NL) begin
                        n_mode  = SM_NLRUN;
                        n_count = '0;
                    end
                end
                SM_NLRUN: begin
                    if (c != CH_NL) begin
                        n_mode  = SM_COUNT;
                        n_count = LEVEL_BITS'(1);
                    end
                end
                default: begin
                    if (r_count < LEVEL_MAX) n_count = r_count + LEVEL_BITS'(1);
                end
            endcase
        end else begin
            n_level = lvl_eff;
            n_mode  = SM_NORMAL;
            n_count = '0;
            n_res   = 2'd1;
            unique case (r_phase)
                PH_KEY: begin
                    priority if (is_lower(c)) begin
                        res_a   = mk_res(K_KEY, c, '0);
                        n_phase = PH_NAME;
                    end else if (is_dig(c)) begin
                        res_a   = mk_res(K_KEY, c, '0);
                        n_phase = PH_INT;
                    end else begin
                        n_phase = PH_HALT;
                    end
                end
                PH_NAME, PH_INT, PH_FRAC: begin
                    priority if ((r_phase == PH_NAME) && (is_lower(c) || c == CH_UNDER)) begin
                        res_a = mk_res(K_KEY, c, '0);
                    end else if ((r_phase != PH_NAME) && is_dig(c)) begin
                        res_a = mk_res(K_KEY, c, '0);
                    end else if ((r_phase == PH_INT) && (c == CH_DOT)) begin
                        res_a   = mk_res(K_KEY, c, '0);
                        n_phase = PH_DOT;
                    end else if (is_single_conn(c)) begin
                        res_a   = mk_res(K_CONN, c, '0);
                        res_b   = mk_res(K_ROW, 8'd0, lvl_out);
                        n_res   = 2'd2;
                        n_phase = PH_KEY;
                    end else if (c == CH_LT) begin
                        res_a   = mk_res(K_CONN, c, '0);
                        n_phase = PH_ARROW;
                    end else begin
                        n_phase = PH_HALT;
                    end
                end
                PH_DOT: begin
                    if (is_dig(c)) begin
                        res_a   = mk_res(K_KEY, c, '0);
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_HALT;
                    end
                end
                PH_ARROW: begin
                    if (c == CH_EQ) begin
                        res_a = mk_res(K_CONN, c, '0);
                    end else begin
                        // row closes, then this byte opens the next key
                        res_a = mk_res(K_ROW, 8'd0, lvl_out);
                        n_res = 2'd2;
                        priority if (is_lower(c)) begin
                            res_b   = mk_res(K_KEY, c, '0);
                            n_phase = PH_NAME;
                        end else if (is_dig(c)) begin
                            res_b   = mk_res(K_KEY, c, '0);
                            n_phase = PH_INT;
                        end else begin
                            n_phase = PH_HALT;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end

        if (n_res == 2'd1) res_a.last = 1'b1;
        if (n_res == 2'd2) res_b.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KEY;
            r_mode  <= SM_NORMAL;
            r_count <= '0;
            r_level <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (in_xfer) begin
                r_phase <= n_phase;
                r_mode  <= n_mode;
                r_count <= n_count;
                r_level <= n_level;
                r_wr    <= r_wr + n_res;
            end
            if (out_xfer) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + (in_xfer ? {1'b0, n_res} : 3'd0) - {2'b00, out_xfer};
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && (n_res != 2'd0)) r_mem[r_wr] <= res_a;
        if (in_xfer && (n_res == 2'd2)) r_mem[r_wr + 2'd1] <= res_b;
    end

endmodule

// File: dv/indent_row_tokenizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_row_tokenizer_test: self-checking bench for the row tokenizer
// Streams of bytes go in: well-formed rows with random keys, connectors and
// indents, with some noise and cut-short streams. A scoreboard tracks the
// parser and the indent counters, predicts every output token and checks the
// tokens in order. Both sides idle at random, and the output side holds off
// once for a long stretch. A final stream carries a long indent run.
// ----------------------------------------------------------------------------
module indent_row_tokenizer_test;
    import irt_pkg::*;

    typedef enum logic [2:0] {
        P_EXPECT_KEY, P_NAME, P_INT, P_DOT, P_FRAC, P_ARROW, P_HALTED
    } t_parse_state;

    typedef enum logic [1:0] {SP_NORMAL, SP_NL_RUN, SP_COUNTING} t_space_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_stim;

    localparam int unsigned WATCHDOG_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned HOLD_OFF_AFTER  = 300;
    localparam int unsigned RANDOM_BYTES    = 900;
    localparam int unsigned INDENT_SPACES   = 150;
    localparam int unsigned REPORT_LIMIT    = 10;

    class token_scoreboard;
        t_res                  expected_tokens[$];
        t_res                  staged[$];
        t_parse_state          state;
        t_space_mode           mode;
        logic [LEVEL_BITS-1:0] run_count;
        logic [LEVEL_BITS-1:0] indent;
        int unsigned           failures;
        int unsigned           reported;
        int unsigned           seen;
        int unsigned           rows;
        int unsigned           errors;
        int unsigned           accepted;

        function new();
            reset_state();
        endfunction

        function void reset_state();
            state     = P_EXPECT_KEY;
            mode      = SP_NORMAL;
            run_count = '0;
            indent    = '0;
        endfunction

        function bit is_az(logic [7:0] c);
            return (c >= "a") && (c <= "z");
        endfunction

        function bit is_num(logic [7:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        function bit is_single_connector(logic [7:0] c);
            case (c)
                ":", ";", ",", "(", ")", "+", "-", "*", "/": return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void stage(logic [2:0] kind, logic [7:0] c, logic [LEVEL_BITS-1:0] lvl);
            t_res r;
            r.kind = kind;
            r.ch   = c;
            if (64'(lvl) > 64'(OUT_LEVEL_MAX))
                r.level = OUT_LEVEL_MAX;
            else
                r.level = OUT_LEVEL_BITS'(lvl);
            r.last = 1'b0;
            staged.push_back(r);
        endfunction

        function void end_row();
            stage(K_ROW, 8'd0, indent);
        endfunction

        function void halt();
            stage(K_ERR, 8'd0, '0);
            state = P_HALTED;
        endfunction

        // a blank run only sets the level if it started with a newline
        function void close_run();
            if (mode != SP_NORMAL) begin
                indent    = run_count;
                mode      = SP_NORMAL;
                run_count = '0;
            end
        endfunction

        function void begin_key(logic [7:0] c);
            if (is_az(c)) begin
                stage(K_KEY, c, '0);
                state = P_NAME;
            end else if (is_num(c)) begin
                stage(K_KEY, c, '0);
                state = P_INT;
            end else begin
                halt();
            end
        endfunction

        function void connect(logic [7:0] c);
            if (is_single_connector(c)) begin
                stage(K_CONN, c, '0);
                end_row();
                state = P_EXPECT_KEY;
            end else if (c == CH_LT) begin
                stage(K_CONN, c, '0);
                state = P_ARROW;
            end else begin
                halt();
            end
        endfunction

        // returns 0 when the byte is dropped because the stream already failed
        function bit predict_byte(logic [7:0] c, logic fin);
            bit taken;
            taken = 1'b1;
            staged.delete();
            if (fin) begin
                close_run();
                case (state)
                    P_EXPECT_KEY: stage(K_ACC, 8'd0, '0);
                    P_ARROW: begin
                        end_row();
                        stage(K_ACC, 8'd0, '0);
                    end
                    P_HALTED: ;
                    default: stage(K_ERR, 8'd0, '0);
                endcase
                reset_state();
            end else if (state == P_HALTED) begin
                taken = 1'b0;
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
                case (mode)
                    SP_NORMAL: begin
                        if (c == CH_NL) begin
                            mode      = SP_NL_RUN;
                            run_count = '0;
                        end
                    end
                    SP_NL_RUN: begin
                        if (c != CH_NL) begin
                            mode      = SP_COUNTING;
                            run_count = LEVEL_BITS'(1);
                        end
                    end
                    default: begin
                        if (run_count != LEVEL_MAX)
                            run_count++;
                    end
                endcase
            end else begin
                close_run();
                case (state)
                    P_EXPECT_KEY: begin_key(c);
                    P_NAME: begin
                        if (is_az(c) || c == CH_UNDER)
                            stage(K_KEY, c, '0);
                        else
                            connect(c);
                    end
                    P_INT: begin
                        if (is_num(c)) begin
                            stage(K_KEY, c, '0);
                        end else if (c == CH_DOT) begin
                            stage(K_KEY, c, '0);
                            state = P_DOT;
                        end else begin
                            connect(c);
                        end
                    end
                    P_DOT: begin
                        if (is_num(c)) begin
                            stage(K_KEY, c, '0);
                            state = P_FRAC;
                        end else begin
                            halt();
                        end
                    end
                    P_FRAC: begin
                        if (is_num(c))
                            stage(K_KEY, c, '0);
                        else
                            connect(c);
                    end
                    P_ARROW: begin
                        if (c == CH_EQ) begin
                            stage(K_CONN, c, '0);
                        end else begin
                            // arrow closes the row; the byte starts the next key
                            end_row();
                            state = P_EXPECT_KEY;
                            begin_key(c);
                        end
                    end
                    default: halt();
                endcase
            end
            if (staged.size() > 0)
                staged[staged.size()-1].last = 1'b1;
            foreach (staged[i])
                expected_tokens.push_back(staged[i]);
            return taken;
        endfunction

        function void complain(string msg);
            failures++;
            if (reported < REPORT_LIMIT) begin
                reported++;
                $display("%s", msg);
            end
        endfunction

        function void check_token(t_res got);
            t_res want;
            seen++;
            if (expected_tokens.size() == 0) begin
                complain($sformatf("token %0d unexpected: kind %0d char %02h level %0d last %0b",
                                   seen, got.kind, got.ch, got.level, got.last));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch ||
                got.level !== want.level || got.last !== want.last) begin
                complain($sformatf({"token %0d mismatch: expected kind %0d char %02h level %0d",
                                    " last %0b, got kind %0d char %02h level %0d last %0b"},
                                   seen, want.kind, want.ch, want.level, want.last,
                                   got.kind, got.ch, got.level, got.last));
            end
            case (want.kind)
                K_ROW: rows++;
                K_ERR: errors++;
                K_ACC: accepted++;
                default: ;
            endcase
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard sb = new();
    t_stim           stim_q[$];
    bit              quiet     = 1'b0;
    bit              held_off  = 1'b0;
    int unsigned     sent_bytes;
    int unsigned     live_bytes;
    int unsigned     streams;

    indent_row_tokenizer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] ch
        .i_s_tlast  (s_tlast),    // is_end
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] out_char, [23:8] row_level
        .o_m_tuser  (m_tuser),    // [2:0] kind
        .o_m_tlast  (m_tlast)     // last
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // mostly back to back, some short gaps, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_byte(logic [7:0] c);
        stim_q.push_back('{ch: c, fin: 1'b0});
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_end();
        stim_q.push_back('{ch: 8'($urandom_range(0, 255)), fin: 1'b1});
    endfunction

    function automatic void maybe_blank();
        if ($urandom_range(0, 11) == 0)
            push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_key();
        int unsigned n;
        if ($urandom_range(0, 1)) begin
            push_byte(8'("a") + 8'($urandom_range(0, 25)));
            n = $urandom_range(0, 6);
            repeat (n) begin
                maybe_blank();
                push_byte(($urandom_range(0, 4) == 0) ? CH_UNDER
                                                      : 8'("a") + 8'($urandom_range(0, 25)));
            end
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                push_byte(8'("0") + 8'($urandom_range(0, 9)));
                maybe_blank();
            end
            if ($urandom_range(0, 4) < 2) begin
                push_byte(CH_DOT);
                maybe_blank();
                n = $urandom_range(1, 3);
                repeat (n) begin
                    push_byte(8'("0") + 8'($urandom_range(0, 9)));
                    maybe_blank();
                end
            end
        end
    endfunction

    // one stream: mostly well-formed rows, sometimes noise, cut short or ended mid-key
    function automatic void build_stream();
        string       conn_set;
        int unsigned n_rows;
        int unsigned r;
        int unsigned cut;
        conn_set = ":;,()+-*/";
        if ($urandom_range(0, 19) == 0) begin
            n_rows = $urandom_range(1, 8);
            repeat (n_rows) push_byte(8'($urandom_range(0, 255)));
        end else begin
            n_rows = $urandom_range(1, 6);
            repeat (n_rows) begin
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 3)) push_byte(CH_NL);
                    repeat ($urandom_range(0, 8)) begin
                        r = $urandom_range(0, 9);
                        push_byte((r < 7) ? CH_SPACE : ((r < 9) ? CH_TAB : CH_NL));
                    end
                end
                maybe_blank();
                add_key();
                maybe_blank();
                if ($urandom_range(0, 4) != 0) begin
                    push_byte(conn_set[$urandom_range(0, 8)]);
                end else begin
                    push_byte(CH_LT);
                    repeat ($urandom_range(0, 3)) begin
                        maybe_blank();
                        push_byte(CH_EQ);
                    end
                end
            end
            if ($urandom_range(0, 9) == 0)
                add_key();
            if ($urandom_range(0, 3) == 0) begin
                push_byte(CH_NL);
                repeat ($urandom_range(0, 4)) push_byte(CH_SPACE);
            end
            if ($urandom_range(0, 7) == 0)
                stim_q.insert($urandom_range(0, stim_q.size()),
                              '{ch: 8'($urandom_range(0, 255)), fin: 1'b0});
            if ($urandom_range(0, 15) == 0 && stim_q.size() > 1) begin
                cut = $urandom_range(1, stim_q.size() - 1);
                while (stim_q.size() > cut)
                    void'(stim_q.pop_back());
            end
        end
        push_end();
    endfunction

    task automatic send_item(input t_stim item);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item.ch;
        s_tlast  <= item.fin;
        do @(posedge clk); while (!s_tready);
        if (sb.predict_byte(item.ch, item.fin))
            live_bytes++;
        sent_bytes++;
        if (item.fin)
            streams++;
    endtask

    task automatic send_all();
        while (stim_q.size() > 0)
            send_item(stim_q.pop_front());
    endtask

    initial begin : result_sink
        int unsigned hold;
        t_res        got;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got.kind  = m_tuser;
                got.ch    = m_tdata[7:0];
                got.level = m_tdata[23:8];
                got.last  = m_tlast;
                sb.check_token(got);
            end
            if (!held_off && sb.seen >= HOLD_OFF_AFTER) begin
                // long back-pressure: the input side has to fill up and stall
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transfer for %0d cycles, %0d tokens still due",
                 idle, sb.expected_tokens.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned base;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stream, then names, fraction, arrow ended by a key, arrow at the end
        push_end();
        push_text("az_:");
        push_text("\n\t 9.0<=");
        push_text(" 1*");
        push_text("q<");
        push_end();
        // end after the dot, a non-ASCII byte then ignored input, blanks only
        push_text("7.");
        push_end();
        push_byte(8'hFF);
        push_text("a");
        push_end();
        push_text(" \n");
        push_end();
        send_all();

        base = sent_bytes;
        while (sent_bytes - base < RANDOM_BYTES) begin
            quiet = ($urandom_range(0, 5) == 0);
            build_stream();
            send_all();
        end

        // a long indent run, mixed blanks, carried into the next rows
        quiet = 1'b1;
        push_byte(CH_NL);
        for (int i = 0; i < INDENT_SPACES; i++)
            push_byte((i % 97 == 5) ? CH_TAB : CH_SPACE);
        push_text("k;m:");
        push_end();
        send_all();
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        while (sb.expected_tokens.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes in %0d streams (%0d parsed), %0d tokens checked",
                 sent_bytes, streams, live_bytes, sb.seen);
        $display("%0d row ends, %0d errors, %0d streams accepted; %0d failures",
                 sb.rows, sb.errors, sb.accepted, sb.failures);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
